// ===== hw/rtl/sc2le_pkg.sv =====
// Package: constants, action codes and scan-code character tables for the line editor.
package sc2le_pkg;

    localparam int unsigned IDX_W          = 7;
    localparam int unsigned TERM_W         = 2;
    localparam int unsigned CHAR_W         = 7;
    localparam int unsigned CODE_W         = 8;
    localparam int unsigned LINE_LIMIT     = 127;
    localparam int unsigned TERMINAL_COUNT = 3;
    localparam int unsigned TABLE_SIZE     = 58;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [TERM_W-1:0] term_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_STORE  = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_LINE   = 3'd4,
        ACT_SWITCH = 3'd5
    } action_t;

    localparam code_t SC_LSHIFT_DN = 8'h2A;
    localparam code_t SC_RSHIFT_DN = 8'h36;
    localparam code_t SC_LSHIFT_UP = 8'hAA;
    localparam code_t SC_RSHIFT_UP = 8'hB6;
    localparam code_t SC_CTRL_DN   = 8'h1D;
    localparam code_t SC_CTRL_UP   = 8'h9D;
    localparam code_t SC_CAPS_DN   = 8'h3A;
    localparam code_t SC_CAPS_UP   = 8'hBA;
    localparam code_t SC_ALT_DN    = 8'h38;
    localparam code_t SC_ALT_UP    = 8'hB8;
    localparam code_t SC_F1        = 8'h3B;
    localparam code_t SC_F2        = 8'h3C;
    localparam code_t SC_F3        = 8'h3D;
    localparam code_t SC_ESC       = 8'h01;
    localparam code_t SC_TAB       = 8'h0F;
    localparam code_t SC_TBL_LO    = 8'h02;
    localparam code_t SC_TBL_HI    = code_t'(TABLE_SIZE - 1);

    localparam char_t CH_BS  = 7'h08;
    localparam char_t CH_NL  = 7'h0A;
    localparam char_t CH_L   = 7'h6C;
    localparam char_t CH_A   = 7'h61;
    localparam char_t CH_Z   = 7'h7A;

    function automatic char_t plain_char(input logic [5:0] c);
        char_t ch;
        case (c)
            6'h02: ch = 7'h31;  6'h03: ch = 7'h32;  6'h04: ch = 7'h33;
            6'h05: ch = 7'h34;  6'h06: ch = 7'h35;  6'h07: ch = 7'h36;
            6'h08: ch = 7'h37;  6'h09: ch = 7'h38;  6'h0A: ch = 7'h39;
            6'h0B: ch = 7'h30;  6'h0C: ch = 7'h2D;  6'h0D: ch = 7'h3D;
            6'h0E: ch = 7'h08;  6'h0F: ch = 7'h20;
            6'h10: ch = 7'h71;  6'h11: ch = 7'h77;  6'h12: ch = 7'h65;
            6'h13: ch = 7'h72;  6'h14: ch = 7'h74;  6'h15: ch = 7'h79;
            6'h16: ch = 7'h75;  6'h17: ch = 7'h69;  6'h18: ch = 7'h6F;
            6'h19: ch = 7'h70;  6'h1A: ch = 7'h5B;  6'h1B: ch = 7'h5D;
            6'h1C: ch = 7'h0A;
            6'h1E: ch = 7'h61;  6'h1F: ch = 7'h73;  6'h20: ch = 7'h64;
            6'h21: ch = 7'h66;  6'h22: ch = 7'h67;  6'h23: ch = 7'h68;
            6'h24: ch = 7'h6A;  6'h25: ch = 7'h6B;  6'h26: ch = 7'h6C;
            6'h27: ch = 7'h3B;  6'h28: ch = 7'h27;  6'h29: ch = 7'h60;
            6'h2B: ch = 7'h5C;
            6'h2C: ch = 7'h7A;  6'h2D: ch = 7'h78;  6'h2E: ch = 7'h63;
            6'h2F: ch = 7'h76;  6'h30: ch = 7'h62;  6'h31: ch = 7'h6E;
            6'h32: ch = 7'h6D;  6'h33: ch = 7'h2C;  6'h34: ch = 7'h2E;
            6'h35: ch = 7'h2F;  6'h39: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic char_t shift_char(input logic [5:0] c);
        char_t ch;
        case (c)
            6'h02: ch = 7'h21;  6'h03: ch = 7'h40;  6'h04: ch = 7'h23;
            6'h05: ch = 7'h24;  6'h06: ch = 7'h25;  6'h07: ch = 7'h5E;
            6'h08: ch = 7'h26;  6'h09: ch = 7'h2A;  6'h0A: ch = 7'h28;
            6'h0B: ch = 7'h29;  6'h0C: ch = 7'h5F;  6'h0D: ch = 7'h2B;
            6'h0E: ch = 7'h08;  6'h0F: ch = 7'h20;
            6'h10: ch = 7'h51;  6'h11: ch = 7'h57;  6'h12: ch = 7'h45;
            6'h13: ch = 7'h52;  6'h14: ch = 7'h54;  6'h15: ch = 7'h59;
            6'h16: ch = 7'h55;  6'h17: ch = 7'h49;  6'h18: ch = 7'h4F;
            6'h19: ch = 7'h50;  6'h1A: ch = 7'h7B;  6'h1B: ch = 7'h7D;
            6'h1C: ch = 7'h0A;
            6'h1E: ch = 7'h41;  6'h1F: ch = 7'h53;  6'h20: ch = 7'h44;
            6'h21: ch = 7'h46;  6'h22: ch = 7'h47;  6'h23: ch = 7'h48;
            6'h24: ch = 7'h4A;  6'h25: ch = 7'h4B;  6'h26: ch = 7'h4C;
            6'h27: ch = 7'h3A;  6'h28: ch = 7'h22;  6'h29: ch = 7'h7E;
            6'h2B: ch = 7'h7C;
            6'h2C: ch = 7'h5A;  6'h2D: ch = 7'h58;  6'h2E: ch = 7'h43;
            6'h2F: ch = 7'h56;  6'h30: ch = 7'h42;  6'h31: ch = 7'h4E;
            6'h32: ch = 7'h4D;  6'h33: ch = 7'h3C;  6'h34: ch = 7'h3E;
            6'h35: ch = 7'h3F;  6'h39: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/scancode_to_line_editor_top.sv =====
// Top level: set-1 scan codes to line-editing actions, one beat per cycle
// while m_ready is high.
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+----------------
//  s_      | s_scan_code, s_read_pending             | in  | s_valid/s_ready
//  m_      | m_action, m_char_code, m_position,      | out | m_valid/m_ready
//          | m_terminal, m_line_reset                |     |
//
// Each accepted beat yields one result beat in the next cycle. Flags and
// line indexes update at the accepting edge. s_ready is high whenever the
// result register is empty or being drained. Synchronous active-low reset
// clears flags, terminal and all line indexes.
module scancode_to_line_editor_top (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  sc2le_pkg::code_t         s_scan_code,
    input  logic                     s_read_pending,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_action,
    output sc2le_pkg::char_t         m_char_code,
    output sc2le_pkg::idx_t          m_position,
    output sc2le_pkg::term_t         m_terminal,
    output logic                     m_line_reset
);
    import sc2le_pkg::*;

    localparam idx_t LIMIT = idx_t'(LINE_LIMIT);

    logic    shift_reg, shift_next;
    logic    ctrl_reg, ctrl_next;
    logic    alt_reg, alt_next;
    logic    caps_down_reg, caps_down_next;
    logic    caps_mode_reg, caps_mode_next;
    term_t   term_reg, term_next;
    idx_t    line_idx_reg [TERMINAL_COUNT];
    idx_t    idx_wr;
    logic    idx_we;

    logic    m_valid_reg;
    action_t action_reg, action_next;
    char_t   char_reg, char_next;
    idx_t    pos_reg, pos_next;
    logic    rst_reg, rst_next;

    logic    accept;
    idx_t    idx;
    char_t   pch;
    char_t   sch;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign idx     = line_idx_reg[term_reg];
    assign pch     = plain_char(s_scan_code[5:0]);
    assign sch     = shift_char(s_scan_code[5:0]);

    always_comb begin
        shift_next     = shift_reg;
        ctrl_next      = ctrl_reg;
        alt_next       = alt_reg;
        caps_down_next = caps_down_reg;
        caps_mode_next = caps_mode_reg;
        term_next      = term_reg;
        idx_we         = 1'b0;
        idx_wr         = idx;
        action_next    = ACT_NONE;
        char_next      = '0;
        pos_next       = '0;
        rst_next       = 1'b0;
        case (s_scan_code)
            SC_LSHIFT_DN, SC_RSHIFT_DN: shift_next = 1'b1;
            SC_LSHIFT_UP, SC_RSHIFT_UP: shift_next = 1'b0;
            SC_CTRL_DN: ctrl_next = 1'b1;
            SC_CTRL_UP: ctrl_next = 1'b0;
            SC_CAPS_DN: caps_down_next = 1'b1;
            SC_CAPS_UP: begin
                caps_down_next = 1'b0;
                caps_mode_next = !caps_mode_reg;
            end
            SC_ALT_DN: alt_next = 1'b1;
            SC_ALT_UP: alt_next = 1'b0;
            SC_F1: begin
                if (alt_reg && (0 < TERMINAL_COUNT)) begin
                    term_next   = term_t'(0);
                    action_next = ACT_SWITCH;
                end
            end
            SC_F2: begin
                if (alt_reg && (1 < TERMINAL_COUNT)) begin
                    term_next   = term_t'(1);
                    action_next = ACT_SWITCH;
                end
            end
            SC_F3: begin
                if (alt_reg && (2 < TERMINAL_COUNT)) begin
                    term_next   = term_t'(2);
                    action_next = ACT_SWITCH;
                end
            end
            SC_ESC, SC_TAB: action_next = ACT_NONE;
            default: begin
                if (s_scan_code inside {[SC_TBL_LO:SC_TBL_HI]}) begin
                    if (ctrl_reg && pch == CH_L) begin
                        action_next = ACT_CLEAR;
                    end else if (pch == CH_BS) begin
                        if (idx != '0) begin
                            idx_we      = 1'b1;
                            idx_wr      = idx - idx_t'(1);
                            action_next = ACT_ERASE;
                            pos_next    = idx - idx_t'(1);
                        end
                    end else if (idx >= LIMIT && pch != CH_NL) begin
                        action_next = ACT_NONE;
                    end else if (pch == CH_NL) begin
                        idx_we      = 1'b1;
                        action_next = ACT_LINE;
                        char_next   = CH_NL;
                        pos_next    = idx;
                        if (s_read_pending) begin
                            idx_wr = (idx < LIMIT) ? idx + idx_t'(1) : idx;
                        end else begin
                            idx_wr   = '0;
                            rst_next = 1'b1;
                        end
                    end else begin
                        idx_we      = 1'b1;
                        idx_wr      = idx + idx_t'(1);
                        action_next = ACT_STORE;
                        pos_next    = idx;
                        if (pch inside {[CH_A:CH_Z]}) begin
                            char_next = (caps_mode_reg != shift_reg) ? sch : pch;
                        end else begin
                            char_next = shift_reg ? sch : pch;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            alt_reg       <= 1'b0;
            caps_down_reg <= 1'b0;
            caps_mode_reg <= 1'b0;
            term_reg      <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < TERMINAL_COUNT; i++) begin
                line_idx_reg[i] <= '0;
            end
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                shift_reg     <= shift_next;
                ctrl_reg      <= ctrl_next;
                alt_reg       <= alt_next;
                caps_down_reg <= caps_down_next;
                caps_mode_reg <= caps_mode_next;
                term_reg      <= term_next;
                m_valid_reg   <= 1'b1;
                if (idx_we) begin
                    line_idx_reg[term_reg] <= idx_wr;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= action_next;
            char_reg   <= char_next;
            pos_reg    <= pos_next;
            rst_reg    <= rst_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = action_reg;
    assign m_char_code  = char_reg;
    assign m_position   = pos_reg;
    assign m_terminal   = term_reg;
    assign m_line_reset = rst_reg;

endmodule
